@@ sv/crc16fb_pkg.sv @@
// ----------------------------------------------------------------------------
// CRC-16 frame builder package
// Shared constants and the byte-wise CRC-16/MODBUS update.
// ----------------------------------------------------------------------------
package crc16fb_pkg;

  localparam logic [7:0]  HEAD_BYTE        = 8'hFA;
  localparam logic [7:0]  TAIL_BYTE        = 8'h0D;
  localparam logic [16:0] BASE_LEN         = 17'd9;
  localparam logic [16:0] ACK_LEN          = 17'd10;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;
  localparam logic [15:0] MAX_FRAME_RESET  = 16'd1024;

  localparam logic        CMD_START        = 1'b0;
  localparam logic        CMD_PAYLOAD      = 1'b1;

  localparam logic [1:0]  ST_OK            = 2'd0;
  localparam logic [1:0]  ST_TOO_LONG      = 2'd1;
  localparam logic [1:0]  ST_OUTSIDE       = 2'd2;
  localparam logic [1:0]  ST_OPEN          = 2'd3;

  localparam int          S_DATA_W         = 64;
  localparam int          M_DATA_W         = 8;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ sv/crc16_frame_builder.sv @@
// ----------------------------------------------------------------------------
// CRC-16 frame builder
// Turns start and payload items into a length-prefixed byte stream that
// closes with a CRC-16/MODBUS and a tail byte.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tuser: cmd; tdata: header fields and payload byte
// m_axis    out        tdata: frame byte; tlast: last of run; tuser: end, status
// cfg       in         max_frame_bytes, always ready
//
// Each accepted item sits in one item register and leaves one byte per cycle
// through the output register, so a payload byte gives one output byte, a closing
// payload byte four, a start six or seven (nine or ten with an empty
// payload) and a rejected item one. The output register sets the rate:
// a stall on m_axis holds the item register and hence s_axis.
// Reset closes the open frame, sets the CRC to 0xFFFF and the limit register to 1024.
// ----------------------------------------------------------------------------
module crc16_frame_builder
  import crc16fb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] device_addr, [15:8] command_code, [23:16] module_id, [24] with_ack,
  // [32:25] ack_code, [48:33] payload_len, [56:49] payload_byte, rest zero
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // [0] cmd
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] frame_byte
  output logic [M_DATA_W-1:0] m_axis_tdata,
  output logic                m_axis_tlast,
  // [0] frame_end, [2:1] status
  output logic [2:0]          m_axis_tuser,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  typedef enum logic [3:0] {
    PH_HEAD, PH_LEN_LO, PH_LEN_HI, PH_DEV, PH_CMD, PH_MOD, PH_ACK,
    PH_DATA, PH_CRC_LO, PH_CRC_HI, PH_TAIL, PH_ERR
  } phase_t;

  logic [15:0] max_frame_bytes;
  logic        frame_open, frame_open_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [15:0] crc, crc_next;

  logic        item_valid;
  phase_t      phase, phase_next, phase_after;
  logic [7:0]  it_dev, it_cmd, it_mod, it_ack, it_pbyte;
  logic        it_ack_en;
  logic [15:0] it_total, it_plen;
  logic [1:0]  it_status;

  logic        out_free, step, is_last, done, accept;
  logic [7:0]  byte_out;
  logic [1:0]  status_out;
  logic        end_out;
  logic [16:0] total_in;
  logic [15:0] plen_in;
  logic [1:0]  status_in;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign step      = item_valid && out_free;
  assign plen_in   = s_axis_tdata[48:33];
  assign total_in  = {1'b0, plen_in} + (s_axis_tdata[24] ? ACK_LEN : BASE_LEN);

  always_comb begin
    is_last         = 1'b0;
    phase_after     = phase;
    byte_out        = 8'h00;
    status_out      = ST_OK;
    end_out         = 1'b0;
    crc_next        = crc;
    frame_open_next = frame_open;
    bytes_left_next = bytes_left;
    unique case (phase)
      PH_HEAD: begin
        byte_out    = HEAD_BYTE;
        crc_next    = CRC_INIT;
        phase_after = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        byte_out    = it_total[7:0];
        phase_after = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        byte_out    = it_total[15:8];
        phase_after = PH_DEV;
      end
      PH_DEV: begin
        byte_out    = it_dev;
        phase_after = PH_CMD;
      end
      PH_CMD: begin
        byte_out    = it_cmd;
        phase_after = PH_MOD;
      end
      PH_MOD, PH_ACK: begin
        byte_out = (phase == PH_ACK) ? it_ack : it_mod;
        if (phase == PH_MOD && it_ack_en) begin
          phase_after = PH_ACK;
        end else if (it_plen == 16'd0) begin
          phase_after = PH_CRC_LO;
        end else begin
          is_last         = 1'b1;
          frame_open_next = 1'b1;
          bytes_left_next = it_plen;
        end
      end
      PH_DATA: begin
        byte_out        = it_pbyte;
        bytes_left_next = bytes_left - 16'd1;
        if (bytes_left == 16'd1) begin
          phase_after = PH_CRC_LO;
        end else begin
          is_last = 1'b1;
        end
      end
      PH_CRC_LO: begin
        byte_out    = crc[7:0];
        phase_after = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        byte_out    = crc[15:8];
        phase_after = PH_TAIL;
      end
      PH_TAIL: begin
        byte_out        = TAIL_BYTE;
        end_out         = 1'b1;
        is_last         = 1'b1;
        crc_next        = CRC_INIT;
        frame_open_next = 1'b0;
        bytes_left_next = 16'd0;
      end
      PH_ERR: begin
        status_out = it_status;
        is_last    = 1'b1;
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
    if (phase == PH_LEN_LO || phase == PH_LEN_HI || phase == PH_DEV ||
        phase == PH_CMD || phase == PH_MOD || phase == PH_ACK || phase == PH_DATA) begin
      crc_next = crc_byte(crc, byte_out);
    end
  end

  assign done          = step && is_last;
  assign s_axis_tready = !item_valid || done;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    status_in  = ST_OK;
    phase_next = PH_ERR;
    if (s_axis_tuser == CMD_START) begin
      if (step ? frame_open_next : frame_open) begin
        status_in = ST_OPEN;
      end else if (total_in > {1'b0, max_frame_bytes}) begin
        status_in = ST_TOO_LONG;
      end else begin
        phase_next = PH_HEAD;
      end
    end else begin
      if (step ? frame_open_next : frame_open) begin
        phase_next = PH_DATA;
      end else begin
        status_in = ST_OUTSIDE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= MAX_FRAME_RESET;
      frame_open      <= 1'b0;
      bytes_left      <= 16'd0;
      crc             <= CRC_INIT;
      item_valid      <= 1'b0;
      phase           <= PH_HEAD;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_frame_bytes <= cfg_data;
      end
      if (step) begin
        frame_open    <= frame_open_next;
        bytes_left    <= bytes_left_next;
        crc           <= crc_next;
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= byte_out;
        m_axis_tlast  <= is_last;
        m_axis_tuser  <= {status_out, end_out};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (accept) begin
        phase <= phase_next;
      end else if (step) begin
        phase <= phase_after;
      end
      if (accept) begin
        item_valid <= 1'b1;
        it_status  <= status_in;
        it_dev     <= s_axis_tdata[7:0];
        it_cmd     <= s_axis_tdata[15:8];
        it_mod     <= s_axis_tdata[23:16];
        it_ack_en  <= s_axis_tdata[24];
        it_ack     <= s_axis_tdata[32:25];
        it_plen    <= plen_in;
        it_pbyte   <= s_axis_tdata[56:49];
        it_total   <= total_in[15:0];
      end else if (done) begin
        item_valid <= 1'b0;
      end
    end
  end

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2:1] != ST_OK |-> m_axis_tlast && !m_axis_tuser[0])
    else $error("error result must stand alone");

  a_tail_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == TAIL_BYTE)
    else $error("frame end must carry the tail byte and close the run");

  a_open_count: assert property (@(posedge clk) disable iff (rst)
    frame_open && !item_valid |-> bytes_left != 16'd0)
    else $error("open frame with no payload bytes left");

  a_crc_idle: assert property (@(posedge clk) disable iff (rst)
    !frame_open && !item_valid |-> crc == CRC_INIT)
    else $error("CRC not restored outside a frame");

  a_data_open: assert property (@(posedge clk) disable iff (rst)
    item_valid && phase == PH_DATA |-> frame_open)
    else $error("payload byte emitted with no open frame");

endmodule

@@ tb/tb_crc16_frame_builder.sv @@
// ----------------------------------------------------------------------------
// CRC-16 frame builder testbench
// Sends start and payload transactions, first from a short table of corner
// cases and then in random frames under several length limits, and checks
// every output byte against an independent prediction of the framing, the
// length field, the CRC-16/MODBUS trailer and the error results.
// ----------------------------------------------------------------------------
module tb_crc16_frame_builder;
  timeunit 1ns;
  timeprecision 1ps;

  import crc16fb_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 300;

  typedef struct packed {
    logic [7:0] fbyte;
    logic       last;
    logic       tail;
    logic [1:0] status;
  } frame_beat_t;

  typedef enum logic {ROW_ITEM, ROW_LIMIT} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        cmd;
    logic [63:0] data;
    logic [15:0] limit;
    logic        typed;
    logic [1:0]  want_status;
  } stim_row_t;

  logic                clk;
  logic                rst           = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic                s_axis_tuser  = CMD_START;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic [2:0]          m_axis_tuser;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [15:0]         cfg_data      = '0;

  frame_beat_t expected_frame_bytes[$];
  logic        open_frame  = 1'b0;
  logic [15:0] bytes_to_go = '0;
  logic [15:0] running_crc = CRC_INIT;
  logic [15:0] frame_limit = MAX_FRAME_RESET;

  int mismatches = 0;
  int cycles     = 0;
  int items_sent = 0;
  int idle_pct   = 20;
  bit hold_req   = 1'b0;

  crc16_frame_builder DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Bit-serial form of the reflected CRC, one data bit per step.
  function automatic logic [15:0] modbus_crc_update(input logic [15:0] crc,
                                                    input logic [7:0]  octet);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ octet[k];
      c  = {1'b0, c[15:1]};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic logic [63:0] pack_item(input logic [7:0] dev, input logic [7:0] code,
                                            input logic [7:0] mid, input logic ack,
                                            input logic [7:0] ackc, input logic [15:0] plen,
                                            input logic [7:0] pb);
    return {7'd0, pb, plen, ackc, ack, mid, code, dev};
  endfunction

  function automatic logic [63:0] rand_item(input logic [15:0] plen, input logic ack);
    return pack_item(8'($urandom), 8'($urandom), 8'($urandom), ack, 8'($urandom), plen,
                     8'($urandom));
  endfunction

  function automatic void push_beat(input logic [7:0] b, input logic last, input logic tail,
                                    input logic [1:0] st);
    expected_frame_bytes.push_back('{fbyte: b, last: last, tail: tail, status: st});
  endfunction

  function automatic void push_crc_byte(input logic [7:0] b);
    push_beat(b, 1'b0, 1'b0, ST_OK);
    running_crc = modbus_crc_update(running_crc, b);
  endfunction

  function automatic void push_trailer();
    push_beat(running_crc[7:0], 1'b0, 1'b0, ST_OK);
    push_beat(running_crc[15:8], 1'b0, 1'b0, ST_OK);
    push_beat(TAIL_BYTE, 1'b0, 1'b1, ST_OK);
    open_frame  = 1'b0;
    bytes_to_go = '0;
    running_crc = CRC_INIT;
  endfunction

  function automatic void predict_frame_bytes(input logic cmd, input logic [63:0] d);
    logic [16:0] total;
    total = {1'b0, d[48:33]} + (d[24] ? ACK_LEN : BASE_LEN);
    if (cmd == CMD_START) begin
      if (open_frame) begin
        push_beat(8'h00, 1'b0, 1'b0, ST_OPEN);
      end else if (total > {1'b0, frame_limit}) begin
        push_beat(8'h00, 1'b0, 1'b0, ST_TOO_LONG);
      end else begin
        running_crc = CRC_INIT;
        push_beat(HEAD_BYTE, 1'b0, 1'b0, ST_OK);
        push_crc_byte(total[7:0]);
        push_crc_byte(total[15:8]);
        push_crc_byte(d[7:0]);
        push_crc_byte(d[15:8]);
        push_crc_byte(d[23:16]);
        if (d[24]) begin
          push_crc_byte(d[32:25]);
        end
        if (d[48:33] == 16'd0) begin
          push_trailer();
        end else begin
          open_frame  = 1'b1;
          bytes_to_go = d[48:33];
        end
      end
    end else if (!open_frame) begin
      push_beat(8'h00, 1'b0, 1'b0, ST_OUTSIDE);
    end else begin
      push_crc_byte(d[56:49]);
      bytes_to_go = bytes_to_go - 16'd1;
      if (bytes_to_go == 16'd0) begin
        push_trailer();
      end
    end
    expected_frame_bytes[expected_frame_bytes.size() - 1].last = 1'b1;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    $display("[%0t] output error: %s", $time, what);
  endtask

  task automatic offer_item(input logic cmd, input logic [63:0] d);
    if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_item(input logic cmd, input logic [63:0] d);
    offer_item(cmd, d);
    predict_frame_bytes(cmd, d);
  endtask

  task automatic set_frame_limit(input logic [15:0] v);
    s_axis_tvalid <= 1'b0;
    while (expected_frame_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    frame_limit = v;
  endtask

  // Mostly complete frames with random contents; the rest are stray payload
  // bytes, oversized starts and starts arriving while a frame is open.
  task automatic random_burst();
    logic [15:0] plen;
    logic        ack;
    int          pick;
    pick = $urandom_range(0, 99);
    ack  = 1'($urandom);
    if (pick < 8) begin
      send_item(CMD_PAYLOAD, rand_item(16'($urandom), ack));
    end else if (pick < 18) begin
      plen = 16'($urandom);
      if ({1'b0, plen} + (ack ? ACK_LEN : BASE_LEN) <= {1'b0, frame_limit}) begin
        plen = 16'hFFFF - 16'($urandom_range(0, 8));
        ack  = 1'b1;
      end
      send_item(CMD_START, rand_item(plen, ack));
    end else begin
      if ($urandom_range(0, 9) == 0) begin
        plen = 16'($urandom_range(15, 60));
      end else begin
        plen = 16'($urandom_range(0, 14));
      end
      send_item(CMD_START, rand_item(plen, ack));
      while (open_frame) begin
        if ($urandom_range(0, 11) == 0) begin
          send_item(CMD_START, rand_item(16'($urandom), 1'($urandom)));
        end
        send_item(CMD_PAYLOAD, rand_item(16'($urandom), 1'($urandom)));
      end
    end
  endtask

  task automatic random_phase(input logic [15:0] limit, input int pct, input int n_items,
                              input bit squeeze);
    int stop_at;
    set_frame_limit(limit);
    idle_pct = pct;
    hold_req = squeeze;
    stop_at  = items_sent + n_items;
    while (items_sent < stop_at) random_burst();
  endtask

  function automatic stim_row_t item_row(input logic cmd, input logic [63:0] d);
    return '{kind: ROW_ITEM, cmd: cmd, data: d, limit: '0, typed: 1'b0, want_status: ST_OK};
  endfunction

  function automatic stim_row_t error_row(input logic cmd, input logic [63:0] d,
                                          input logic [1:0] st);
    return '{kind: ROW_ITEM, cmd: cmd, data: d, limit: '0, typed: 1'b1, want_status: st};
  endfunction

  function automatic stim_row_t limit_row(input logic [15:0] v);
    return '{kind: ROW_LIMIT, cmd: CMD_START, data: '0, limit: v, typed: 1'b0,
             want_status: ST_OK};
  endfunction

  initial begin : sink
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : monitor
    frame_beat_t seen;
    frame_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen = '{fbyte: m_axis_tdata, last: m_axis_tlast, tail: m_axis_tuser[0],
               status: m_axis_tuser[2:1]};
      if (expected_frame_bytes.size() == 0) begin
        note_mismatch($sformatf("unexpected byte %02h last %0d end %0d status %0d",
                                seen.fbyte, seen.last, seen.tail, seen.status));
      end else begin
        want = expected_frame_bytes.pop_front();
        if (seen !== want) begin
          note_mismatch($sformatf(
            "byte %02h last %0d end %0d status %0d, wanted %02h %0d %0d %0d",
            seen.fbyte, seen.last, seen.tail, seen.status,
            want.fbyte, want.last, want.tail, want.status));
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t directed[$];

    directed.push_back(error_row(CMD_PAYLOAD,
      pack_item(8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 16'h0000, 8'hFF), ST_OUTSIDE));
    directed.push_back(item_row(CMD_START,
      pack_item(8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 16'h0000, 8'h00)));
    directed.push_back(item_row(CMD_START,
      pack_item(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 16'h0000, 8'hFF)));
    directed.push_back(error_row(CMD_START,
      pack_item(8'hFF, 8'hFF, 8'hFF, 1'b0, 8'hFF, 16'hFFFF, 8'hFF), ST_TOO_LONG));
    directed.push_back(item_row(CMD_START,
      pack_item(8'h12, 8'h34, 8'h56, 1'b1, 8'hA5, 16'd3, 8'h00)));
    directed.push_back(error_row(CMD_START,
      pack_item(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 16'h0000, 8'hFF), ST_OPEN));
    directed.push_back(item_row(CMD_PAYLOAD,
      pack_item(8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 16'h0000, 8'h00)));
    directed.push_back(item_row(CMD_PAYLOAD,
      pack_item(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 16'hFFFF, 8'hFF)));
    directed.push_back(item_row(CMD_PAYLOAD,
      pack_item(8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 16'h0000, 8'h5A)));
    directed.push_back(item_row(CMD_START,
      pack_item(8'hC3, 8'h3C, 8'h81, 1'b0, 8'hFF, 16'd1, 8'h00)));
    directed.push_back(item_row(CMD_PAYLOAD,
      pack_item(8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 16'h0000, 8'h80)));
    directed.push_back(error_row(CMD_PAYLOAD,
      pack_item(8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 16'h0000, 8'h01), ST_OUTSIDE));
    directed.push_back(limit_row(16'd9));
    directed.push_back(item_row(CMD_START,
      pack_item(8'hAA, 8'h55, 8'h0F, 1'b0, 8'h00, 16'd0, 8'h00)));
    directed.push_back(error_row(CMD_START,
      pack_item(8'hAA, 8'h55, 8'h0F, 1'b1, 8'h77, 16'd0, 8'h00), ST_TOO_LONG));
    directed.push_back(error_row(CMD_START,
      pack_item(8'hAA, 8'h55, 8'h0F, 1'b0, 8'h00, 16'd1, 8'h00), ST_TOO_LONG));
    directed.push_back(limit_row(16'hFFFF));
    directed.push_back(error_row(CMD_START,
      pack_item(8'h01, 8'h02, 8'h03, 1'b1, 8'h04, 16'hFFFF, 8'h00), ST_TOO_LONG));
    directed.push_back(error_row(CMD_START,
      pack_item(8'h01, 8'h02, 8'h03, 1'b1, 8'h04, 16'd65526, 8'h00), ST_TOO_LONG));
    directed.push_back(limit_row(16'd12));
    directed.push_back(item_row(CMD_START,
      pack_item(8'h5A, 8'hA5, 8'hC3, 1'b0, 8'h00, 16'd3, 8'h00)));
    directed.push_back(item_row(CMD_PAYLOAD,
      pack_item(8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 16'h0000, 8'h11)));
    directed.push_back(item_row(CMD_PAYLOAD,
      pack_item(8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 16'h0000, 8'h22)));
    directed.push_back(item_row(CMD_PAYLOAD,
      pack_item(8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 16'h0000, 8'h33)));
    directed.push_back(error_row(CMD_START,
      pack_item(8'h5A, 8'hA5, 8'hC3, 1'b1, 8'h00, 16'd3, 8'h00), ST_TOO_LONG));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_LIMIT) begin
        set_frame_limit(directed[i].limit);
      end else begin
        offer_item(directed[i].cmd, directed[i].data);
        if (directed[i].typed) begin
          push_beat(8'h00, 1'b1, 1'b0, directed[i].want_status);
        end else begin
          predict_frame_bytes(directed[i].cmd, directed[i].data);
        end
      end
    end

    random_phase(16'd1024, 20, 70, 1'b0);
    random_phase(16'($urandom_range(9, 30)), 20, 60, 1'b0);
    random_phase(16'hFFFF, 0, 50, 1'b0);
    random_phase(16'd9, 20, 30, 1'b0);
    random_phase(16'd200, 20, 80, 1'b1);
    random_phase(16'd1024, 0, 60, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (expected_frame_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/crc16fb_pkg.sv
sv/crc16_frame_builder.sv
tb/tb_crc16_frame_builder.sv
